/* rtl/dsched_pkg.sv */
package dsched_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int CYL_BITS     = 16;
    localparam int IDX_W        = $clog2(MAX_REQUESTS);
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int SEEK_W       = 22;
    localparam int TURN_W       = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int MODE_W       = 3;
    localparam int OUT_DATA_W   = 48;

    localparam logic [SEEK_W-1:0] SEEK_MAX = '1;
    localparam logic [TURN_W-1:0] TURN_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CYL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_DIR = 2'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT,
        ST_OUT
    } state_t;

endpackage

/* rtl/dsched_ram.sv */
module dsched_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/disk_arm_request_scheduler_unit.sv */
// disk arm request scheduler: loads a batch, then emits the service order
// load: one request per cycle while s_tready is high (held low during scheduling)
// each result takes one full pass over the request store (through its single
// read port), then the emit and output states; sweep modes make a second pass
// for the result where the first side runs empty; fcfs reads only its own entry
// aresetn is synchronous, active low: clears control, config regs and sums
module disk_arm_request_scheduler_unit
    import dsched_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CYL_BITS-1:0]   s_tdata,   // [15:0] request_cylinder
    input  logic                  s_tlast,   // last_request
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] served_cylinder, [16] turned,
                                             // [38:17] seek_total, [45:39] turn_count
    output logic                  m_tlast    // last_served
);

    // config registers
    logic [MODE_W-1:0]   mode_reg;
    logic [CYL_BITS-1:0] start_cyl_reg;
    logic                start_dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_FCFS;
            start_cyl_reg <= '0;
            start_dir_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[MODE_W-1:0];
                REG_START_CYL: start_cyl_reg <= cfg_data[CYL_BITS-1:0];
                REG_START_DIR: start_dir_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic is_sstf, is_sweep, is_cscan, is_fcfs;
    assign is_sstf  = (mode_reg == MODE_SSTF);
    assign is_cscan = (mode_reg == MODE_CSCAN);
    assign is_sweep = (mode_reg == MODE_SCAN) || is_cscan || (mode_reg == MODE_LOOK);
    assign is_fcfs  = !is_sstf && !is_sweep;

    // sequencer state
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;          // requests held
    logic [CNT_W-1:0]      k_reg, k_next;              // results delivered
    logic [CNT_W-1:0]      issue_reg, issue_next;      // next store address to read
    logic [CNT_W-1:0]      scan_end_reg, scan_end_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  phase_reg, phase_next;      // sweep: second side
    logic                  turn_done_reg, turn_done_next;
    logic [MAX_REQUESTS-1:0] mask_reg, mask_next;
    logic                  found_reg, found_next;
    logic [CYL_BITS-1:0]   best_metric_reg, best_metric_next;
    logic [CYL_BITS-1:0]   best_cyl_reg, best_cyl_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [CYL_BITS-1:0]   head_reg, head_next;
    logic                  dir_reg, dir_next;
    logic [SEEK_W-1:0]     seek_reg, seek_next;
    logic [TURN_W-1:0]     turns_reg, turns_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    // request store
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [CYL_BITS-1:0] ram_rdata;

    assign ram_we    = (state_reg == ST_LOAD) && s_tvalid && (cnt_reg < CNT_W'(MAX_REQUESTS));
    assign ram_raddr = issue_reg[IDX_W-1:0];

    dsched_ram #(.WIDTH(CYL_BITS), .DEPTH(MAX_REQUESTS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared pick unit: metric of the entry just read, compared to the best so far
    logic                upper_side, want_max, side_ok, eligible, better;
    logic [CYL_BITS-1:0] dist_c, metric;
    assign upper_side = phase_reg ? !start_dir_reg : start_dir_reg;
    assign want_max   = !phase_reg ? !start_dir_reg : (is_cscan ? !start_dir_reg : start_dir_reg);
    assign side_ok    = !is_sweep || ((ram_rdata >= start_cyl_reg) == upper_side);
    assign dist_c     = (ram_rdata >= head_reg) ? ram_rdata - head_reg : head_reg - ram_rdata;
    assign metric     = is_sstf ? dist_c : (want_max ? ~ram_rdata : ram_rdata);
    assign eligible   = !mask_reg[rd_idx_reg] && side_ok;
    assign better     = eligible && (!found_reg || (metric < best_metric_reg));

    // emit arithmetic
    logic [CYL_BITS-1:0] emit_dist;
    logic [SEEK_W:0]     seek_sum;
    logic                emit_dir, emit_turn;
    assign emit_dist = (best_cyl_reg >= head_reg) ? best_cyl_reg - head_reg
                                                  : head_reg - best_cyl_reg;
    assign seek_sum  = {1'b0, seek_reg} + (SEEK_W+1)'(emit_dist);
    assign emit_dir  = (best_cyl_reg >= head_reg);
    assign emit_turn = is_sweep ? (phase_reg && !turn_done_reg) : (emit_dir != dir_reg);

    logic [CNT_W-1:0] n_load;
    assign n_load = cnt_reg + CNT_W'(ram_we);

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        k_next           = k_reg;
        issue_next       = issue_reg;
        scan_end_next    = scan_end_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = rd_idx_reg;
        phase_next       = phase_reg;
        turn_done_next   = turn_done_reg;
        mask_next        = mask_reg;
        found_next       = found_reg;
        best_metric_next = best_metric_reg;
        best_cyl_next    = best_cyl_reg;
        best_idx_next    = best_idx_reg;
        head_next        = head_reg;
        dir_next         = dir_reg;
        seek_next        = seek_reg;
        turns_next       = turns_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cnt_next = n_load;
                    if (s_tlast) begin
                        // new batch: head and sums start over
                        state_next     = ST_SCAN;
                        k_next         = '0;
                        issue_next     = '0;
                        scan_end_next  = is_fcfs ? '0 : n_load - CNT_W'(1);
                        phase_next     = 1'b0;
                        turn_done_next = 1'b0;
                        mask_next      = '0;
                        found_next     = 1'b0;
                        head_next      = start_cyl_reg;
                        dir_next       = start_dir_reg;
                        seek_next      = '0;
                        turns_next     = '0;
                    end
                end
            end
            ST_SCAN: begin
                // one store read per cycle, its result evaluated in the cycle after
                if (issue_reg <= scan_end_reg) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[IDX_W-1:0];
                    issue_next  = issue_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    if (better) begin
                        found_next       = 1'b1;
                        best_metric_next = metric;
                        best_cyl_next    = ram_rdata;
                        best_idx_next    = rd_idx_reg;
                    end
                    if (CNT_W'(rd_idx_reg) == scan_end_reg) begin
                        if (better || found_reg) begin
                            state_next = ST_EMIT;
                        end else begin
                            // first side exhausted: sweep the other side
                            phase_next = 1'b1;
                            issue_next = '0;
                        end
                    end
                end
            end
            ST_EMIT: begin
                mask_next[best_idx_reg] = 1'b1;
                head_next = best_cyl_reg;
                if (!is_sweep) dir_next = emit_dir;
                if (phase_reg) turn_done_next = 1'b1;
                seek_next = (seek_sum > (SEEK_W+1)'(SEEK_MAX)) ? SEEK_MAX : seek_sum[SEEK_W-1:0];
                turns_next = (emit_turn && (turns_reg != TURN_MAX)) ? turns_reg + TURN_W'(1)
                                                                   : turns_reg;
                m_valid_next = 1'b1;
                m_data_next  = {2'b00, turns_next, seek_next, emit_turn, best_cyl_reg};
                m_last_next  = (k_reg + CNT_W'(1) == cnt_reg);
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    k_next       = k_reg + CNT_W'(1);
                    found_next   = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end else begin
                        state_next    = ST_SCAN;
                        issue_next    = is_fcfs ? k_reg + CNT_W'(1) : '0;
                        scan_end_next = is_fcfs ? k_reg + CNT_W'(1) : cnt_reg - CNT_W'(1);
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            k_reg         <= '0;
            issue_reg     <= '0;
            scan_end_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            turn_done_reg <= 1'b0;
            mask_reg      <= '0;
            found_reg     <= 1'b0;
            head_reg      <= '0;
            dir_reg       <= 1'b1;
            seek_reg      <= '0;
            turns_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            issue_reg     <= issue_next;
            scan_end_reg  <= scan_end_next;
            rd_vld_reg    <= rd_vld_next;
            phase_reg     <= phase_next;
            turn_done_reg <= turn_done_next;
            mask_reg      <= mask_next;
            found_reg     <= found_next;
            head_reg      <= head_next;
            dir_reg       <= dir_next;
            seek_reg      <= seek_next;
            turns_reg     <= turns_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        rd_idx_reg      <= rd_idx_next;
        best_metric_reg <= best_metric_next;
        best_cyl_reg    <= best_cyl_next;
        best_idx_reg    <= best_idx_next;
        m_data_reg      <= m_data_next;
        m_last_reg      <= m_last_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // checks
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg == (state_reg == ST_OUT))
        else $error("result valid outside output state");

    a_scan_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg != '0) && (k_reg < cnt_reg))
        else $error("scan with no pending request");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (CNT_W'(rd_idx_reg) <= scan_end_reg) && (scan_end_reg < cnt_reg))
        else $error("store read beyond loaded requests");

    a_emit_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> found_reg && !mask_reg[best_idx_reg])
        else $error("emit without an unserved pick");

endmodule

/* bench/disk_arm_request_scheduler_checker.sv */
module disk_arm_request_scheduler_checker
    import dsched_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [CYL_BITS-1:0]   s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [CYL_BITS-1:0] cyl;
        logic                turned;
        logic [SEEK_W-1:0]   seek;
        logic [TURN_W-1:0]   turns;
        logic                last;
    } visit_t;

    visit_t                service_order[$];
    logic [MODE_W-1:0]     cur_mode;
    logic [CYL_BITS-1:0]   cur_start;
    logic                  cur_dir;
    logic [CYL_BITS-1:0]   held_cyl [MAX_REQUESTS];
    int                    held_count;

    // running arm state while a batch is planned
    logic [CYL_BITS-1:0]   arm_pos;
    logic                  arm_dir;
    int                    arm_seek;
    int                    arm_turns;

    assign pending = service_order.size();

    task automatic visit(input logic [CYL_BITS-1:0] c, input bit t, input bit lst);
        visit_t v;
        int seek_step;
        seek_step = (c >= arm_pos) ? int'(c - arm_pos) : int'(arm_pos - c);
        if (t && arm_turns < int'(TURN_MAX)) arm_turns++;
        arm_seek = (arm_seek + seek_step > int'(SEEK_MAX)) ? int'(SEEK_MAX)
                                                           : arm_seek + seek_step;
        arm_pos = c;
        v.cyl = c;
        v.turned = t;
        v.seek = arm_seek[SEEK_W-1:0];
        v.turns = arm_turns[TURN_W-1:0];
        v.last = lst;
        service_order.push_back(v);
    endtask

    function automatic bit direction_flip(input logic [CYL_BITS-1:0] c);
        logic nd;
        bit t;
        nd = (c >= arm_pos);
        t = (nd != arm_dir);
        arm_dir = nd;
        return t;
    endfunction

    task automatic plan_batch();
        int n, i, j, k, split, best, bestd, d;
        logic [CYL_BITS-1:0] srt [MAX_REQUESTS];
        logic [CYL_BITS-1:0] ord [MAX_REQUESTS];
        bit tf [MAX_REQUESTS];
        bit [MAX_REQUESTS-1:0] done;
        logic [CYL_BITS-1:0] v;
        n = held_count;
        arm_pos = cur_start;
        arm_dir = cur_dir;
        arm_seek = 0;
        arm_turns = 0;
        done = '0;
        if (cur_mode == MODE_SSTF) begin
            for (k = 0; k < n; k++) begin
                best = -1;
                bestd = 0;
                for (i = 0; i < n; i++) begin
                    if (done[i]) continue;
                    d = (held_cyl[i] >= arm_pos) ? int'(held_cyl[i] - arm_pos)
                                                 : int'(arm_pos - held_cyl[i]);
                    // strict compare keeps the earliest request on ties
                    if (best < 0 || d < bestd) begin
                        best = i;
                        bestd = d;
                    end
                end
                done[best] = 1'b1;
                visit(held_cyl[best], direction_flip(held_cyl[best]), k + 1 == n);
            end
        end else if (cur_mode == MODE_SCAN || cur_mode == MODE_CSCAN
                     || cur_mode == MODE_LOOK) begin
            for (i = 0; i < n; i++) begin
                v = held_cyl[i];
                j = i;
                while (j > 0 && srt[j-1] > v) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = v;
            end
            split = 0;
            while (split < n && srt[split] < cur_start) split++;
            k = 0;
            if (cur_dir) begin
                for (i = split; i < n; i++) begin ord[k] = srt[i]; tf[k++] = 0; end
                if (cur_mode == MODE_CSCAN) begin
                    for (i = 0; i < split; i++) begin ord[k] = srt[i]; tf[k++] = (i == 0); end
                end else begin
                    for (i = split; i > 0; i--) begin
                        ord[k] = srt[i-1];
                        tf[k++] = (i == split);
                    end
                end
            end else begin
                for (i = split; i > 0; i--) begin ord[k] = srt[i-1]; tf[k++] = 0; end
                if (cur_mode == MODE_CSCAN) begin
                    for (i = n; i > split; i--) begin ord[k] = srt[i-1]; tf[k++] = (i == n); end
                end else begin
                    for (i = split; i < n; i++) begin ord[k] = srt[i]; tf[k++] = (i == split); end
                end
            end
            for (i = 0; i < n; i++) visit(ord[i], tf[i], i + 1 == n);
        end else begin
            // fcfs, and the unused mode codes
            for (k = 0; k < n; k++)
                visit(held_cyl[k], direction_flip(held_cyl[k]), k + 1 == n);
        end
        held_count = 0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode <= MODE_FCFS;
            cur_start <= '0;
            cur_dir <= 1'b1;
            held_count = 0;
            service_order.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MODE:      cur_mode <= cfg_data[MODE_W-1:0];
                    REG_START_CYL: cur_start <= cfg_data[CYL_BITS-1:0];
                    REG_START_DIR: cur_dir <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (held_count < MAX_REQUESTS) begin
                    held_cyl[held_count] = s_tdata;
                    held_count++;
                end
                if (s_tlast) plan_batch();
            end
            if (m_tvalid && m_tready) begin
                if (service_order.size() == 0) begin
                    $error("unexpected result cyl=%0d", m_tdata[15:0]);
                    errors++;
                end else begin
                    visit_t e;
                    e = service_order.pop_front();
                    if (m_tdata[15:0] !== e.cyl) begin
                        $error("served_cylinder exp %0d got %0d", e.cyl, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[16] !== e.turned) begin
                        $error("turned exp %0d got %0d", e.turned, m_tdata[16]);
                        errors++;
                    end
                    if (m_tdata[38:17] !== e.seek) begin
                        $error("seek_total exp %0d got %0d", e.seek, m_tdata[38:17]);
                        errors++;
                    end
                    if (m_tdata[45:39] !== e.turns) begin
                        $error("turn_count exp %0d got %0d", e.turns, m_tdata[45:39]);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_served exp %0d got %0d", e.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_disk_arm_request_scheduler_unit.sv */
module tb_disk_arm_request_scheduler_unit;
    import dsched_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [CYL_BITS-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    int                    errors;
    int                    pending;

    // no random idling on either side while this is set
    bit                    calm = 1'b0;
    int                    sent = 0;

    always #5 aclk = ~aclk;

    disk_arm_request_scheduler_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    disk_arm_request_scheduler_checker i_check (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .errors(errors), .pending(pending)
    );

    // result side back-pressure, ready dropped with about 9 percent chance
    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end

    // drain everything queued, then let the block settle before a config write
    task automatic wait_idle();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // write all three registers back to back, idle block only
    task automatic set_config(input logic [MODE_W-1:0] md, input logic [15:0] sc,
                              input logic sd);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data <= CFG_DATA_W'(md);
        @(posedge aclk);
        cfg_index <= REG_START_CYL;
        cfg_data <= sc;
        @(posedge aclk);
        cfg_index <= REG_START_DIR;
        cfg_data <= CFG_DATA_W'(sd);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // send one batch, last flag on the final request
    task automatic send_batch(input logic [15:0] cyls[$]);
        for (int i = 0; i < cyls.size(); i++) begin
            while (!calm && $urandom_range(99) < 9) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= cyls[i];
            s_tlast <= (i == cyls.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sent++;
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [15:0] batch[$];
        logic [15:0] sc;
        int n, lo, hi;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fcfs with direction flips at the cylinder extremes
        set_config(MODE_FCFS, 16'd0, 1'b1);
        send_batch('{16'hFFFF, 16'd0, 16'hFFFF, 16'd100});
        // sstf with an equal-distance tie, earliest request wins
        set_config(MODE_SSTF, 16'd1000, 1'b0);
        send_batch('{16'd990, 16'd1010, 16'd1000, 16'd5, 16'hFFFF});
        // sweeps in both directions
        set_config(MODE_SCAN, 16'd500, 1'b1);
        send_batch('{16'd600, 16'd100, 16'd500, 16'd900});
        set_config(MODE_CSCAN, 16'd500, 1'b0);
        send_batch('{16'd600, 16'd100, 16'd900, 16'd200});
        set_config(MODE_CSCAN, 16'd500, 1'b1);
        send_batch('{16'd600, 16'd100, 16'd200});
        // look with an empty first side
        set_config(MODE_LOOK, 16'd0, 1'b0);
        send_batch('{16'd7, 16'd3});
        // unused mode code acts as fcfs, single-request batch
        set_config(3'd7, 16'hFFFF, 1'b1);
        send_batch('{16'd42});

        // random batches
        while (sent < 220) begin
            calm = (sent >= 100 && sent < 150);
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(3))
                    0: sc = 16'd0;
                    1: sc = 16'hFFFF;
                    default: sc = 16'($urandom_range(65535));
                endcase
                set_config(MODE_W'($urandom_range(7)), sc, 1'($urandom_range(1)));
            end
            // mostly short batches, now and then one that nearly fills, fills or overflows the store
            n = ($urandom_range(14) == 0) ? $urandom_range(MAX_REQUESTS + 2, MAX_REQUESTS - 1)
                                         : $urandom_range(10, 1);
            lo = $urandom_range(65535 - 64);
            hi = lo + 64;
            batch.delete();
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(1))
                    batch.push_back(16'($urandom_range(65535)));
                else
                    batch.push_back(16'($urandom_range(hi, lo)));
            end
            send_batch(batch);
        end
        calm = 1'b0;

        wait_idle();
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("disk_arm_request_scheduler_unit: match");
        end else begin
            $display("disk_arm_request_scheduler_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("disk_arm_request_scheduler_unit: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dsched_pkg.sv
rtl/dsched_ram.sv
rtl/disk_arm_request_scheduler_unit.sv
bench/disk_arm_request_scheduler_checker.sv
bench/tb_disk_arm_request_scheduler_unit.sv
